>>> hw/rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// Shared constants and types for the modular inverse pipeline.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Extra bits on the signed Bezout coefficient beyond the operand width.
  localparam int unsigned T_GUARD = 2;

  // Control bits that travel with each transaction down the pipeline.
  typedef struct packed {
    logic valid;   // stage holds a live transaction
    logic mod_ok;  // modulus is at least 2
  } ctl_t;

endpackage

>>> hw/rtl/mie_if.sv
// ----------------------------------------------------------------------------
// mie_in_if / mie_out_if
// Valid/ready channels for operands and results.
// ----------------------------------------------------------------------------
interface mie_in_if #(
  parameter int unsigned WIDTH = 16
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface mie_out_if #(
  parameter int unsigned WIDTH = 16
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] inverse;
  logic             invertible;

  modport source (output valid, output inverse, output invertible, input ready);
  modport sink   (input valid, input inverse, input invertible, output ready);
endinterface

>>> hw/rtl/mie_step.sv
// ----------------------------------------------------------------------------
// mie_step
// One registered Euclid step: swap, subtract an aligned multiple of b, or hold once b is zero.
// ----------------------------------------------------------------------------
module mie_step #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned TW    = WIDTH + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  mie_pkg::ctl_t        ctl_i,
  input  logic [WIDTH-1:0]     m_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  input  logic signed [TW-1:0] ta_i,
  input  logic signed [TW-1:0] tb_i,
  output mie_pkg::ctl_t        ctl_o,
  output logic [WIDTH-1:0]     m_o,
  output logic [WIDTH-1:0]     a_o,
  output logic [WIDTH-1:0]     b_o,
  output logic signed [TW-1:0] ta_o,
  output logic signed [TW-1:0] tb_o
);
  import mie_pkg::*;

  localparam int unsigned LW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  function automatic logic [LW-1:0] msb_pos(input logic [WIDTH-1:0] x);
    logic [LW-1:0] pos;
    pos = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (x[i]) pos = LW'(i);
    end
    return pos;
  endfunction

  ctl_t                 ctl_q;
  logic [WIDTH-1:0]     m_q, a_q, a_d, b_q, b_d;
  logic signed [TW-1:0] ta_q, ta_d, tb_q, tb_d;
  logic [LW-1:0]        lead_gap;
  logic [LW-1:0]        shamt;
  logic [WIDTH-1:0]     b_sh;
  logic                 fits;

  always_comb begin
    lead_gap = msb_pos(a_i) - msb_pos(b_i);
    b_sh     = b_i << lead_gap;
    fits     = (b_sh <= a_i);
    shamt    = fits ? lead_gap : (lead_gap - LW'(1));
    a_d      = a_i;
    b_d      = b_i;
    ta_d     = ta_i;
    tb_d     = tb_i;
    if (b_i == '0) begin
      // finished: hold
    end else if (a_i < b_i) begin
      a_d  = b_i;
      b_d  = a_i;
      ta_d = tb_i;
      tb_d = ta_i;
    end else begin
      a_d  = a_i - (fits ? b_sh : (b_sh >> 1));
      ta_d = ta_i - (tb_i <<< shamt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q  <= m_i;
      a_q  <= a_d;
      b_q  <= b_d;
      ta_q <= ta_d;
      tb_q <= tb_d;
    end
  end

  assign ctl_o = ctl_q;
  assign m_o   = m_q;
  assign a_o   = a_q;
  assign b_o   = b_q;
  assign ta_o  = ta_q;
  assign tb_o  = tb_q;

endmodule

>>> hw/rtl/mie_final.sv
// ----------------------------------------------------------------------------
// mie_final
// Gcd check, sign fix of the coefficient and the output register.
// ----------------------------------------------------------------------------
module mie_final #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned TW    = WIDTH + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mie_pkg::ctl_t        ctl_i,
  input  logic [WIDTH-1:0]     m_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic signed [TW-1:0] ta_i,
  output logic                 adv_o,
  mie_out_if.source            out_o
);
  import mie_pkg::*;

  logic                 valid_q;
  logic [WIDTH-1:0]     inv_q, inv_d;
  logic                 ok_q, ok_d;
  logic signed [TW-1:0] fixed;

  assign adv_o = !valid_q || out_o.ready;

  always_comb begin
    ok_d  = ctl_i.mod_ok && (a_i == WIDTH'(1));
    fixed = ta_i[TW-1] ? (ta_i + TW'(m_i)) : ta_i;
    inv_d = ok_d ? fixed[WIDTH-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      inv_q <= inv_d;
      ok_q  <= ok_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.inverse    = inv_q;
  assign out_o.invertible = ok_q;

endmodule

>>> hw/rtl/modular_inverse_euclid.sv
// ----------------------------------------------------------------------------
// modular_inverse_euclid
// Pipelined modular inverse by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// Returns value^-1 mod modulus with invertible set, or 0 with invertible
// clear when gcd(value, modulus) != 1, value is zero, or modulus < 2. The
// block is a chain of 4*WIDTH+6 register stages (70 at WIDTH=16); each stage
// does one Euclid micro-step (a swap of the remainder pair, or subtraction of
// the largest power-of-two multiple of b that fits), so every transaction
// finishes inside the chain. A new transaction is accepted every cycle while the
// output is not held; each result passes through the stage chain and then the
// output register. The whole chain stalls together when the output is held.
// ----------------------------------------------------------------------------
module modular_inverse_euclid #(
  parameter int unsigned WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mie_in_if.sink   in_i,
  mie_out_if.source out_o
);
  import mie_pkg::*;

  localparam int unsigned TW   = WIDTH + T_GUARD;
  // subtract steps <= 2*WIDTH-1, swaps <= division count (< 2*WIDTH+3)
  localparam int unsigned NSTG = 4 * WIDTH + 6;

  ctl_t                 ctl_w [NSTG+1];
  logic [WIDTH-1:0]     m_w   [NSTG+1];
  logic [WIDTH-1:0]     a_w   [NSTG+1];
  logic [WIDTH-1:0]     b_w   [NSTG+1];
  logic signed [TW-1:0] ta_w  [NSTG+1];
  logic signed [TW-1:0] tb_w  [NSTG+1];
  logic                 adv;

  // Seed: (a, b) = (modulus, value), (ta, tb) = (0, 1).
  assign in_i.ready    = adv;
  assign ctl_w[0].valid  = in_i.valid;
  assign ctl_w[0].mod_ok = (in_i.modulus > WIDTH'(1));
  assign m_w[0]  = in_i.modulus;
  assign a_w[0]  = in_i.modulus;
  assign b_w[0]  = in_i.value;
  assign ta_w[0] = '0;
  assign tb_w[0] = TW'(1);

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    mie_step #(
      .WIDTH(WIDTH),
      .TW   (TW)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .ctl_i (ctl_w[s]),
      .m_i   (m_w[s]),
      .a_i   (a_w[s]),
      .b_i   (b_w[s]),
      .ta_i  (ta_w[s]),
      .tb_i  (tb_w[s]),
      .ctl_o (ctl_w[s+1]),
      .m_o   (m_w[s+1]),
      .a_o   (a_w[s+1]),
      .b_o   (b_w[s+1]),
      .ta_o  (ta_w[s+1]),
      .tb_o  (tb_w[s+1])
    );
  end

  mie_final #(
    .WIDTH(WIDTH),
    .TW   (TW)
  ) u_final (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl_w[NSTG]),
    .m_i   (m_w[NSTG]),
    .a_i   (a_w[NSTG]),
    .ta_i  (ta_w[NSTG]),
    .adv_o (adv),
    .out_o (out_o)
  );

`ifndef ASSERT_OFF
  a_inv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.invertible |-> out_o.inverse != '0)
    else $error("invertible result with zero inverse");

  a_noinv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.invertible |-> out_o.inverse == '0)
    else $error("non-invertible result with nonzero inverse");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while pipeline is stalled");
`endif

endmodule
